// ===== src/host_ip_address_canonicalizer_top_defines.svh =====
// Assertion macro used by the checker file.
`ifndef HOST_IP_ADDRESS_CANONICALIZER_TOP_DEFINES_SVH
`define HOST_IP_ADDRESS_CANONICALIZER_TOP_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define HIAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ===== src/hiac_pkg.sv =====
package hiac_pkg;

    typedef struct packed {
        logic [7:0] host_char;
        logic       last_char;
    } hiac_in_t;

    typedef struct packed {
        logic        is_ip;
        logic [31:0] address;
        logic [2:0]  part_count;
    } hiac_out_t;

    // Value of one finished part, as handed from the front to the back.
    typedef struct packed {
        logic        oct_ok;
        logic [32:0] oct_val;
        logic        plain_ok;
        logic [32:0] plain_val;
    } hiac_part_t;

    // Everything the back end needs to judge one complete hostname.
    typedef struct packed {
        hiac_part_t [3:0] parts;
        logic [2:0]       part_number;
        logic             bad;
        logic             allow_octal;
    } hiac_job_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LX    = 8'h78;
    localparam logic [7:0] CHAR_UX    = 8'h58;
    localparam int         MAX_PARTS  = 4;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        // Bit 4 set marks a hex digit; bits 3..0 hold its value.
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic [32:0] acc_step(input logic [32:0] acc,
                                             input logic [1:0]  radix_sel,
                                             input logic [3:0]  digit);
        // radix_sel: 0 octal, 1 decimal, 2 hex. Bit 32 is sticky overflow.
        logic [36:0] n;
        logic [36:0] a;
        a = {5'd0, acc[31:0]};
        unique case (radix_sel)
            2'd0:    n = (a << 3) + {33'd0, digit};
            2'd1:    n = (a << 3) + (a << 1) + {33'd0, digit};
            default: n = (a << 4) + {33'd0, digit};
        endcase
        return {acc[32] | (n[36:32] != 5'd0), n[31:0]};
    endfunction

endpackage

// ===== src/hiac_front.sv =====
module hiac_front
    import hiac_pkg::*;
#(
    parameter int SPACE_CUT_LENGTH = 15
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  hiac_in_t  in_item,
    output logic      job_valid,
    input  logic      job_ready,
    output hiac_job_t job
);
    localparam int CW = $clog2(SPACE_CUT_LENGTH + 2);

    logic [CW-1:0]   char_count_reg, char_count_next;
    logic            space_seen_reg, space_seen_next;
    logic            bad_char_reg, bad_char_next;
    logic [2:0]      part_number_reg, part_number_next;
    logic [1:0]      part_position_reg, part_position_next;
    logic            f_zero_reg, f_dec_reg, f_oct_reg, f_hex_reg, f_xseen_reg, f_hdig_reg;
    logic            f_zero_next, f_dec_next, f_oct_next, f_hex_next, f_xseen_next, f_hdig_next;
    logic            allow_octal_reg, allow_octal_next;
    logic [32:0]     oct_reg, oct_next, dec_reg, dec_next, hex_reg, hex_next;
    hiac_part_t [3:0] saved_reg, saved_next;
    logic            job_valid_reg, job_valid_next;
    hiac_job_t       job_reg, job_next;

    logic       accept;
    logic [7:0] c;
    logic [4:0] hv;
    logic       is_dec, finish, store;
    logic [2:0] pn_fin;
    hiac_part_t fin_part;

    assign full      = job_valid_reg && !job_ready;
    assign accept    = push && !full;
    assign c         = in_item.host_char;
    assign hv        = hex_val(c);
    assign is_dec    = c >= 8'h30 && c <= 8'h39;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        char_count_next    = char_count_reg;
        space_seen_next    = space_seen_reg;
        bad_char_next      = bad_char_reg;
        part_number_next   = part_number_reg;
        part_position_next = part_position_reg;
        f_zero_next  = f_zero_reg;  f_dec_next   = f_dec_reg;
        f_oct_next   = f_oct_reg;   f_hex_next   = f_hex_reg;
        f_xseen_next = f_xseen_reg; f_hdig_next  = f_hdig_reg;
        allow_octal_next = allow_octal_reg;
        oct_next = oct_reg; dec_next = dec_reg; hex_next = hex_reg;
        saved_next = saved_reg;
        job_valid_next = job_valid_reg && !job_ready;
        job_next = job_reg;
        finish = 1'b0;
        fin_part = '0;
        pn_fin = part_number_reg;
        store = 1'b0;

        if (accept) begin
            if (char_count_reg <= CW'(SPACE_CUT_LENGTH))
                char_count_next = char_count_reg + 1'b1;
            if (!space_seen_reg) begin
                if (c == CHAR_SPACE) begin
                    space_seen_next = 1'b1;
                    finish = 1'b1;
                end else if (c == CHAR_DOT) begin
                    finish = 1'b1;
                end else if (hv[4] || c == CHAR_LX || c == CHAR_UX) begin
                    if (part_position_reg == 2'd0) begin
                        f_oct_next = 1'b1;
                        f_zero_next = c == CHAR_ZERO;
                        f_dec_next = is_dec;
                        f_hex_next = 1'b0; f_xseen_next = 1'b0; f_hdig_next = 1'b0;
                    end else begin
                        if (!is_dec) f_dec_next = 1'b0;
                        if (!(c >= 8'h30 && c <= 8'h37)) f_oct_next = 1'b0;
                        if (part_position_reg == 2'd1) begin
                            if (f_zero_reg && (c == CHAR_LX || c == CHAR_UX))
                                f_hex_next = 1'b1;
                        end else begin
                            if (!hv[4]) f_hex_next = 1'b0;
                            else f_hdig_next = 1'b1;
                            if (f_hex_reg && hv[4])
                                hex_next = acc_step(hex_reg, 2'd2, hv[3:0]);
                        end
                        if (f_zero_reg && !f_xseen_reg) begin
                            if (c == CHAR_LX) f_xseen_next = 1'b1;
                            else if (c == 8'h38 || c == 8'h39) allow_octal_next = 1'b0;
                        end
                    end
                    if (is_dec) begin
                        oct_next = acc_step(oct_reg, 2'd0, {1'b0, c[2:0]});
                        dec_next = acc_step(dec_reg, 2'd1, c[3:0]);
                    end
                    if (part_position_reg < 2'd2)
                        part_position_next = part_position_reg + 1'b1;
                end else begin
                    bad_char_next = 1'b1;
                end
            end
            if (in_item.last_char && !space_seen_reg)
                finish = 1'b1;

            // The part is judged with this item's character already folded in.
            if (finish) begin
                if (part_position_next != 2'd0) begin
                    fin_part.oct_ok = f_zero_next && f_oct_next && part_position_next >= 2'd2;
                    fin_part.oct_val = oct_next;
                    if (f_dec_next) begin
                        fin_part.plain_ok = 1'b1;
                        fin_part.plain_val = dec_next;
                    end else if (f_hex_next && f_hdig_next) begin
                        fin_part.plain_ok = 1'b1;
                        fin_part.plain_val = hex_next;
                    end
                    if (part_number_reg < 3'(MAX_PARTS)) begin
                        saved_next[part_number_reg[1:0]] = fin_part;
                        store = 1'b1;
                    end
                    if (part_number_reg <= 3'(MAX_PARTS))
                        pn_fin = part_number_reg + 1'b1;
                end
                part_number_next = pn_fin;
                part_position_next = 2'd0;
                f_zero_next = 1'b0; f_dec_next = 1'b0; f_oct_next = 1'b0;
                f_hex_next = 1'b0; f_xseen_next = 1'b0; f_hdig_next = 1'b0;
                oct_next = '0; dec_next = '0; hex_next = '0;
            end

            if (in_item.last_char) begin
                job_valid_next = 1'b1;
                job_next.parts = saved_next;
                job_next.part_number = pn_fin;
                job_next.bad = bad_char_next ||
                    (space_seen_next && char_count_next > CW'(SPACE_CUT_LENGTH));
                job_next.allow_octal = allow_octal_next;
                char_count_next = '0;
                space_seen_next = 1'b0;
                bad_char_next = 1'b0;
                part_number_next = '0;
                allow_octal_next = 1'b1;
                part_position_next = 2'd0;
                f_zero_next = 1'b0; f_dec_next = 1'b0; f_oct_next = 1'b0;
                f_hex_next = 1'b0; f_xseen_next = 1'b0; f_hdig_next = 1'b0;
                oct_next = '0; dec_next = '0; hex_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_count_reg <= '0;
            space_seen_reg <= 1'b0;
            bad_char_reg <= 1'b0;
            part_number_reg <= '0;
            part_position_reg <= '0;
            f_zero_reg <= 1'b0; f_dec_reg <= 1'b0; f_oct_reg <= 1'b0;
            f_hex_reg <= 1'b0; f_xseen_reg <= 1'b0; f_hdig_reg <= 1'b0;
            allow_octal_reg <= 1'b1;
            oct_reg <= '0; dec_reg <= '0; hex_reg <= '0;
            job_valid_reg <= 1'b0;
        end else begin
            char_count_reg <= char_count_next;
            space_seen_reg <= space_seen_next;
            bad_char_reg <= bad_char_next;
            part_number_reg <= part_number_next;
            part_position_reg <= part_position_next;
            f_zero_reg <= f_zero_next; f_dec_reg <= f_dec_next; f_oct_reg <= f_oct_next;
            f_hex_reg <= f_hex_next; f_xseen_reg <= f_xseen_next; f_hdig_reg <= f_hdig_next;
            allow_octal_reg <= allow_octal_next;
            oct_reg <= oct_next; dec_reg <= dec_next; hex_reg <= hex_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
            saved_reg <= saved_next;
        job_reg <= job_next;
    end
endmodule

// ===== src/hiac_back.sv =====
module hiac_back
    import hiac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  hiac_job_t job,
    output logic      empty,
    input  logic      pop,
    output hiac_out_t result
);
    logic      valid_reg, valid_next;
    hiac_out_t out_reg, out_next;
    logic      take;

    assign job_ready = !valid_reg || pop;
    assign take      = job_valid && job_ready;
    assign empty     = !valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        logic        ok;
        logic [31:0] addr;
        logic [32:0] v;
        logic [2:0]  n;
        ok = !job.bad && job.part_number >= 3'd1 && job.part_number <= 3'(MAX_PARTS);
        n = job.part_number;
        addr = '0;
        for (int i = 0; i < MAX_PARTS; i++) begin
            if (3'(i) < n) begin
                v = '0;
                if (job.allow_octal && job.parts[i].oct_ok) v = job.parts[i].oct_val;
                else if (job.parts[i].plain_ok) v = job.parts[i].plain_val;
                else ok = 1'b0;
                if (v[32]) ok = 1'b0;
                if (3'(i + 1) < n)
                    addr = addr | ({24'd0, v[7:0]} << (8 * (3 - i)));
                else
                    unique case (n)
                        3'd1:    addr = addr | v[31:0];
                        3'd2:    addr = addr | {8'd0, v[23:0]};
                        3'd3:    addr = addr | {16'd0, v[15:0]};
                        default: addr = addr | {24'd0, v[7:0]};
                    endcase
            end
        end
        out_next.is_ip = ok;
        out_next.address = ok ? addr : 32'd0;
        out_next.part_count = ok ? n : 3'd0;
        valid_next = take || (valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take) out_reg <= out_next;
    end
endmodule

// ===== src/host_ip_address_canonicalizer_top.sv =====
// Parses hostnames byte by byte as inet_aton-style IPv4 addresses. One byte is
// taken every cycle unless the front stalls; a byte marked last_char yields one
// result via the front's job register, then the back end's output register.
// The front end holds the per-part accumulators and a one-entry job register
// that hands finished hostnames to the judging back end, whose output register
// holds the result until popped; the front stalls only when both are occupied.
module host_ip_address_canonicalizer_top
    import hiac_pkg::*;
#(
    parameter int SPACE_CUT_LENGTH = 15
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  hiac_in_t  in_item,
    output logic      empty,
    input  logic      pop,
    output hiac_out_t result
);
    logic      job_valid, job_ready;
    hiac_job_t job;

    hiac_front #(.SPACE_CUT_LENGTH(SPACE_CUT_LENGTH)) u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .job_valid, .job_ready, .job
    );

    hiac_back u_back (
        .clk, .rst_n, .job_valid, .job_ready, .job,
        .empty, .pop, .result
    );
endmodule

// ===== src/hiac_checker.sv =====
`include "host_ip_address_canonicalizer_top_defines.svh"
module hiac_checker
    import hiac_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input hiac_in_t  in_item,
    input logic      empty,
    input logic      pop,
    input hiac_out_t result
);
    `HIAC_ASSERT(a_not_ip_zero, clk, rst_n, !empty && !result.is_ip |-> result.address == 32'd0 && result.part_count == 3'd0, "non-IP result carries data")
    `HIAC_ASSERT(a_ip_count, clk, rst_n, !empty && result.is_ip |-> result.part_count >= 3'd1 && result.part_count <= 3'd4, "bad part count")
    `HIAC_ASSERT(a_last_makes_result, clk, rst_n, push && !full && in_item.last_char && empty |=> ##1 !empty, "result missing after last byte")
    `HIAC_ASSERT(a_hold, clk, rst_n, !empty && !pop |=> !empty && $stable(result), "waiting result changed")
endmodule

bind host_ip_address_canonicalizer_top hiac_checker u_hiac_checker (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .result
);

// ===== tb/sv/host_ip_address_canonicalizer_top_tb.sv =====
`timescale 1ns / 100ps

module host_ip_address_canonicalizer_top_tb
    import hiac_pkg::*;
();

    localparam int CUT_LEN  = 15;
    localparam int NPARTS   = 4;
    localparam int LATENCY  = 8;

    typedef enum int { FORM_DEC, FORM_OCT, FORM_HEX, FORM_JUNK } part_form_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    hiac_in_t  in_item;
    logic      empty;
    logic      pop;
    hiac_out_t result;

    host_ip_address_canonicalizer_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .result(result)
    );

    // Predictor state for the hostname in progress.
    int unsigned  name_len;
    bit           cut_by_space;
    bit           junk_seen;
    int unsigned  parts_done;
    int unsigned  pos_in_part;
    bit           f_zero, f_dec, f_oct, f_hex, f_xseen, f_hdig;
    bit           octal_allowed;
    logic [32:0]  acc_oct, acc_dec, acc_hex;
    logic [33:0]  part_oct [NPARTS];
    logic [33:0]  part_plain [NPARTS];

    hiac_out_t    expected_results[$];
    int           error_count;
    bit           hold_pop;
    bit           idle_enable;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int hexdig(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [32:0] grow(input logic [32:0] acc, input int radix,
                                         input int digit);
        logic [63:0] n;
        n = 64'(acc[31:0]) * radix + digit;
        return {acc[32] | (n[63:32] != 0), n[31:0]};
    endfunction

    function automatic void clear_host_part();
        pos_in_part = 0;
        {f_zero, f_dec, f_oct, f_hex, f_xseen, f_hdig} = '0;
        acc_oct = '0;
        acc_dec = '0;
        acc_hex = '0;
    endfunction

    function automatic void clear_hostname();
        name_len = 0;
        cut_by_space = 0;
        junk_seen = 0;
        parts_done = 0;
        octal_allowed = 1;
        clear_host_part();
    endfunction

    function automatic void close_part();
        logic [33:0] plain;
        if (pos_in_part != 0) begin
            plain = '0;
            if (f_dec) plain = {1'b1, acc_dec};
            else if (f_hex && f_hdig) plain = {1'b1, acc_hex};
            if (parts_done < NPARTS) begin
                part_oct[parts_done] = {f_zero && f_oct && pos_in_part >= 2, acc_oct};
                part_plain[parts_done] = plain;
            end
            if (parts_done <= NPARTS) parts_done++;
        end
        clear_host_part();
    endfunction

    function automatic void take_part_char(input logic [7:0] c);
        int  hv;
        bit  dec;
        hv = hexdig(c);
        dec = (c >= "0" && c <= "9");
        if (pos_in_part == 0) begin
            {f_zero, f_dec, f_oct, f_hex, f_xseen, f_hdig} = '0;
            f_oct = 1;
            f_zero = (c == "0");
            f_dec = dec;
        end else begin
            if (!dec) f_dec = 0;
            if (!(c >= "0" && c <= "7")) f_oct = 0;
            if (pos_in_part == 1) begin
                if (f_zero && (c == "x" || c == "X")) f_hex = 1;
            end else begin
                if (hv < 0) f_hex = 0;
                else f_hdig = 1;
                if (f_hex && hv >= 0) acc_hex = grow(acc_hex, 16, hv);
            end
            if (f_zero && !f_xseen) begin
                if (c == "x") f_xseen = 1;
                else if (c == "8" || c == "9") octal_allowed = 0;
            end
        end
        if (dec) begin
            acc_oct = grow(acc_oct, 8, (c - "0") & 7);
            acc_dec = grow(acc_dec, 10, c - "0");
        end
        if (pos_in_part < 2) pos_in_part++;
    endfunction

    // Advances the predictor by one byte and queues the verdict on the last one.
    function automatic void predict_hostname_byte(input hiac_in_t it);
        logic [7:0]  c;
        bit          ok;
        logic [31:0] addr;
        logic [33:0] v;
        hiac_out_t   r;
        int          nb;
        c = it.host_char;
        if (name_len <= CUT_LEN) name_len++;
        if (!cut_by_space) begin
            if (c == CHAR_SPACE) begin
                cut_by_space = 1;
                close_part();
            end else if (c == CHAR_DOT) close_part();
            else if (hexdig(c) >= 0 || c == CHAR_LX || c == CHAR_UX) take_part_char(c);
            else junk_seen = 1;
        end
        if (!it.last_char) return;
        if (!cut_by_space) close_part();
        addr = '0;
        ok = !junk_seen && !(cut_by_space && name_len > CUT_LEN)
             && parts_done >= 1 && parts_done <= NPARTS;
        for (int i = 0; ok && i < parts_done; i++) begin
            if (octal_allowed && part_oct[i][33]) v = part_oct[i];
            else if (part_plain[i][33]) v = part_plain[i];
            else begin
                ok = 0;
                break;
            end
            if (v[32]) begin
                ok = 0;
                break;
            end
            if (i + 1 < parts_done) addr |= 32'(v[7:0]) << (8 * (3 - i));
            else begin
                nb = NPARTS + 1 - parts_done;
                addr |= (nb >= 4) ? v[31:0] : (v[31:0] & ((32'd1 << (8 * nb)) - 1));
            end
        end
        r.is_ip = ok;
        r.address = ok ? addr : '0;
        r.part_count = ok ? 3'(parts_done) : '0;
        expected_results.push_back(r);
        clear_hostname();
    endfunction

    task automatic send_byte(input logic [7:0] c, input bit last);
        while (idle_enable && $urandom_range(99) < 21) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        in_item.host_char <= c;
        in_item.last_char <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_hostname_byte(hiac_in_t'{host_char: c, last_char: last});
        @(negedge clk);
    endtask

    task automatic send_hostname(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    function automatic string random_part(input part_form_t form);
        string s;
        int    n;
        string hexchars;
        hexchars = "0123456789abcdefABCDEF";
        s = "";
        case (form)
            FORM_DEC: begin
                n = $urandom_range(1, ($urandom_range(9) == 0) ? 11 : 3);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
            end
            FORM_OCT: begin
                n = $urandom_range(1, ($urandom_range(9) == 0) ? 12 : 4);
                s = "0";
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
            end
            FORM_HEX: begin
                n = $urandom_range(0, ($urandom_range(9) == 0) ? 9 : 3);
                s = $urandom_range(1) ? "0x" : "0X";
                for (int i = 0; i < n; i++) s = {s, string'(hexchars[$urandom_range(21)])};
            end
            default: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(255)))};
            end
        endcase
        return s;
    endfunction

    task automatic test_directed();
        send_hostname("1.2.3.4");
        send_hostname("255.255.255.255");
        send_hostname("0x7f.1");
        send_hostname("0300.0250.1.1");
        send_hostname("4294967295");
        send_hostname("4294967296");
        send_hostname("0xffffffff");
        send_hostname("010.09.1");
        send_hostname("1.2.3.4.5");
        send_hostname("..1..2..");
        send_hostname("...");
        send_hostname("1.2 junk");
        send_hostname("1.2.3.4 and then more");
        send_hostname("1.2.g");
        send_hostname("0x");
        send_hostname("0Xa.0xB.0xc");
        send_hostname("08x.1");
        send_hostname("0x8.010");
        send_hostname("1.65535");
        send_hostname(" ");
        send_byte(8'hff, 1'b1);
        send_byte(8'h80, 1'b1);
        send_hostname("037777777777");
        drain();
    endtask

    task automatic test_random_hostnames(input int count);
        string s;
        int    n;
        for (int k = 0; k < count; k++) begin
            s = "";
            n = $urandom_range(1, 5);
            for (int p = 0; p < n; p++) begin
                if (p != 0) s = {s, "."};
                if ($urandom_range(9) == 0) s = {s, "."};
                s = {s, random_part(part_form_t'(($urandom_range(19) == 0) ? FORM_JUNK
                                                 : $urandom_range(2)))};
            end
            if ($urandom_range(9) == 0) s = {s, " ", random_part(FORM_JUNK)};
            send_hostname(s);
        end
    endtask

    task automatic test_output_backpressure();
        hold_pop = 1;
        fork
            test_random_hostnames(6);
            begin
                repeat (200) @(negedge clk);
                hold_pop = 0;
            end
        join
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        error_count = 0;
        hold_pop = 0;
        idle_enable = 0;
        clear_hostname();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        idle_enable = 1;
        test_random_hostnames(8);
        test_output_backpressure();
        test_random_hostnames(8);
        drain();
        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    // Sink: random pops, stall-free early, paused in the backpressure test.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge clk);
            pop <= !hold_pop && (!idle_enable || $urandom_range(99) >= 21);
        end
    end

    always @(posedge clk) begin
        hiac_out_t e;
        if (rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, result);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (result.is_ip !== e.is_ip || result.address !== e.address
                    || result.part_count !== e.part_count) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, result);
                    error_count++;
                end
            end
        end
    end
endmodule
